/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk; BTBC_ASSERT is disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BTBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BTBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/btbc_pkg.sv */
// ----------------------------------------------------------------------------
// btbc_pkg
// types and constants of the branch target buffer cost block
// ----------------------------------------------------------------------------
package btbc_pkg;

	// number of buffer entries, a power of two (slot is the low address bits)
	localparam int BTB_ENTRIES = 128;
	localparam int IDX_W       = $clog2(BTB_ENTRIES);

	localparam int ADDR_W  = 64;
	localparam int SIZE_W  = 4;
	localparam int COST_W  = 8;
	localparam int TOTAL_W = 32;
	localparam int CTR_W   = 2;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PREDICTOR_MODE     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MISPREDICT_PENALTY = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BTB_MISS_PENALTY   = 2'd2;

	// register reset values
	localparam logic              RST_PREDICTOR_MODE     = 1'b1;
	localparam logic [COST_W-1:0] RST_MISPREDICT_PENALTY = 8'd4;
	localparam logic [COST_W-1:0] RST_BTB_MISS_PENALTY   = 8'd5;

	// counter limits and threshold
	localparam logic [CTR_W-1:0] CTR_MAX    = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MIN    = 2'd0;
	localparam logic [CTR_W-1:0] CTR_TAKEN  = 2'd2;

	// cost of an instruction that needs no penalty
	localparam logic [COST_W-1:0] BASE_COST = 8'd1;

	// one buffer entry as stored in memory
	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic              conditional;
		logic [CTR_W-1:0]  counter;
	} btbc_entry_t;

endpackage

/* hw/rtl/btbc_ifs.sv */
// ----------------------------------------------------------------------------
// btbc channel interfaces
// valid/ready channels for instruction items and result items
// ----------------------------------------------------------------------------
interface btbc_instr_if;
	logic                              valid;
	logic                              ready;
	logic [btbc_pkg::ADDR_W-1:0]       instr_address;
	logic [btbc_pkg::SIZE_W-1:0]       instr_size;
	logic                              is_branch;
	logic                              is_conditional;
	logic [btbc_pkg::ADDR_W-1:0]       next_address;

	modport source (
		output valid, instr_address, instr_size, is_branch, is_conditional, next_address,
		input  ready
	);
	modport sink (
		input  valid, instr_address, instr_size, is_branch, is_conditional, next_address,
		output ready
	);
endinterface

interface btbc_result_if;
	logic                              valid;
	logic                              ready;
	logic [btbc_pkg::COST_W-1:0]       item_cycles;
	logic [btbc_pkg::TOTAL_W-1:0]      total_cycles;
	logic                              btb_hit;
	logic                              mispredicted;

	modport source (
		output valid, item_cycles, total_cycles, btb_hit, mispredicted,
		input  ready
	);
	modport sink (
		input  valid, item_cycles, total_cycles, btb_hit, mispredicted,
		output ready
	);
endinterface

/* hw/rtl/btb_two_bit_predictor_cost_top.sv */
// ----------------------------------------------------------------------------
// btb_two_bit_predictor_cost_top
// direct-mapped branch target buffer with 2-bit counters, charging cycles
// ----------------------------------------------------------------------------
// usage
//   instr carries one retired instruction per item; result returns one item
//   per instruction: its cycle cost, the running 32-bit total, hit and
//   mispredict flags. the apb port sets predictor mode and the two penalties;
//   write it only while no item is in flight.
// pipeline and throughput
//   an item is accepted and its entry is read from the entry memory into
//   the lookup stage at that edge; the result register is loaded when the
//   lookup stage advances. one item per cycle sustained while result.ready
//   holds; the read-modify-write of the entry memory allows that rate, with
//   the write of one item forwarded to the read of the next when both hit
//   the same slot.
// reset
//   all entry valid bits, the total and the registers go to their reset
//   values at once; no clearing pass is needed.
// stall
//   while a result waits on result.ready the lookup stage holds one more
//   item, then instr.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btb_two_bit_predictor_cost_top (
	input  logic                            clk,
	input  logic                            arst_n,
	btbc_instr_if.sink                      instr,
	btbc_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [btbc_pkg::PADDR_W-1:0]    paddr,
	input  logic [btbc_pkg::PDATA_W-1:0]    pwdata,
	output logic [btbc_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	// configuration registers
	logic                          predictor_mode_q;
	logic [btbc_pkg::COST_W-1:0]   mispredict_penalty_q;
	logic [btbc_pkg::COST_W-1:0]   btb_miss_penalty_q;
	logic [btbc_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	// entry storage
	btbc_pkg::btbc_entry_t         mem [btbc_pkg::BTB_ENTRIES];
	btbc_pkg::btbc_entry_t         rd_data_q;
	logic [btbc_pkg::BTB_ENTRIES-1:0] valid_q;

	// lookup stage
	logic                          valid_s1;
	logic [btbc_pkg::ADDR_W-1:0]   addr_s1;
	logic [btbc_pkg::ADDR_W-1:0]   next_s1;
	logic [btbc_pkg::SIZE_W-1:0]   size_s1;
	logic                          branch_s1;
	logic                          cond_s1;
	logic [btbc_pkg::IDX_W-1:0]    idx_s1;
	logic                          fwd_sel_s1;
	btbc_pkg::btbc_entry_t         fwd_data_s1;

	// running total and result register
	logic [btbc_pkg::TOTAL_W-1:0]  total_q;
	logic                          out_valid_q;
	logic [btbc_pkg::COST_W-1:0]   out_cost_q;
	logic [btbc_pkg::TOTAL_W-1:0]  out_total_q;
	logic                          out_hit_q;
	logic                          out_mispred_q;

	// datapath
	logic                          accept;
	logic                          advance;
	logic [btbc_pkg::IDX_W-1:0]    idx_in;
	btbc_pkg::btbc_entry_t         entry;
	logic                          hit;
	logic                          taken;
	logic                          pred_taken;
	logic                          mispred;
	logic [btbc_pkg::CTR_W-1:0]    ctr_next;
	logic [btbc_pkg::COST_W-1:0]   cost;
	logic [btbc_pkg::TOTAL_W-1:0]  total_next;
	logic                          wr_en;
	btbc_pkg::btbc_entry_t         wr_data;

	// apb decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[btbc_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			btbc_pkg::REG_PREDICTOR_MODE:     prdata[0] = predictor_mode_q;
			btbc_pkg::REG_MISPREDICT_PENALTY: prdata[btbc_pkg::COST_W-1:0] = mispredict_penalty_q;
			btbc_pkg::REG_BTB_MISS_PENALTY:   prdata[btbc_pkg::COST_W-1:0] = btb_miss_penalty_q;
			default:                          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_mode_q     <= btbc_pkg::RST_PREDICTOR_MODE;
			mispredict_penalty_q <= btbc_pkg::RST_MISPREDICT_PENALTY;
			btb_miss_penalty_q   <= btbc_pkg::RST_BTB_MISS_PENALTY;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				btbc_pkg::REG_PREDICTOR_MODE:     predictor_mode_q <= pwdata[0];
				btbc_pkg::REG_MISPREDICT_PENALTY:
					mispredict_penalty_q <= pwdata[btbc_pkg::COST_W-1:0];
				btbc_pkg::REG_BTB_MISS_PENALTY:
					btb_miss_penalty_q <= pwdata[btbc_pkg::COST_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || advance;
	assign accept      = instr.valid && instr.ready;
	assign idx_in      = instr.instr_address[btbc_pkg::IDX_W-1:0];

	// entry read, with the write in the same cycle forwarded
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q <= mem[idx_in];
		end
		if (wr_en) begin
			mem[idx_s1] <= wr_data;
		end
	end

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= instr.instr_address;
			next_s1     <= instr.next_address;
			size_s1     <= instr.instr_size;
			branch_s1   <= instr.is_branch;
			cond_s1     <= instr.is_conditional;
			idx_s1      <= idx_in;
			fwd_sel_s1  <= wr_en && (idx_s1 == idx_in);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// hit check, prediction and cost
	always_comb begin
		entry      = fwd_sel_s1 ? fwd_data_s1 : rd_data_q;
		hit        = branch_s1 && valid_q[idx_s1] && (entry.tag == addr_s1);
		taken      = next_s1 != (addr_s1 + {{(btbc_pkg::ADDR_W-btbc_pkg::SIZE_W){1'b0}}, size_s1});
		pred_taken = predictor_mode_q && (entry.counter >= btbc_pkg::CTR_TAKEN);
		mispred    = hit && entry.conditional && (pred_taken != taken);
		if (taken) begin
			ctr_next = (entry.counter == btbc_pkg::CTR_MAX) ? btbc_pkg::CTR_MAX
				: entry.counter + 2'd1;
		end else begin
			ctr_next = (entry.counter == btbc_pkg::CTR_MIN) ? btbc_pkg::CTR_MIN
				: entry.counter - 2'd1;
		end
		priority if (branch_s1 && !hit) begin
			cost = btb_miss_penalty_q;
		end else if (mispred) begin
			cost = mispredict_penalty_q;
		end else begin
			cost = btbc_pkg::BASE_COST;
		end
		total_next = total_q + {{(btbc_pkg::TOTAL_W-btbc_pkg::COST_W){1'b0}}, cost};
	end

	// write back: install on miss, counter update on dynamic conditional hit
	always_comb begin
		wr_data = entry;
		wr_en   = 1'b0;
		if (advance && branch_s1) begin
			if (!hit) begin
				wr_en               = 1'b1;
				wr_data.tag         = addr_s1;
				wr_data.conditional = cond_s1;
				wr_data.counter     = btbc_pkg::CTR_MIN;
			end else if (entry.conditional && predictor_mode_q) begin
				wr_en           = 1'b1;
				wr_data.counter = ctr_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (advance) begin
			total_q <= total_next;
			if (branch_s1) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_cost_q    <= cost;
			out_total_q   <= total_next;
			out_hit_q     <= hit;
			out_mispred_q <= mispred;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.item_cycles  = out_cost_q;
	assign result.total_cycles = out_total_q;
	assign result.btb_hit      = out_hit_q;
	assign result.mispredicted = out_mispred_q;

	// checks
	`BTBC_ASSERT(a_branch_sets_valid, advance && branch_s1 |=> valid_q[$past(idx_s1)],
		"branch did not leave its slot valid")
	`BTBC_ASSERT(a_total_tracks, advance |=> total_q == $past(total_q) + $past({24'd0, cost}),
		"running total out of step with item cost")
	`BTBC_ASSERT(a_mispred_needs_hit, out_valid_q && out_mispred_q |-> out_hit_q,
		"mispredict flagged without a buffer hit")
	`BTBC_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid_q,
		"result valid during reset")

endmodule

/* sim/btb_two_bit_predictor_cost_top_tb.sv */
// ----------------------------------------------------------------------------
// btb_two_bit_predictor_cost_top_tb
// drives retired instruction items into the branch target buffer cost block
// under several predictor settings, predicts each cost item in a scoreboard
// and compares it field by field, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module btb_two_bit_predictor_cost_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 7;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 200;
	localparam int POOL_SIZE      = 24;
	localparam int TIMEOUT_CYCLES = 200000;

	// register index past the end of the map, writes to it are dropped
	localparam logic [btbc_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [btbc_pkg::ADDR_W-1:0] instr_address;
		logic [btbc_pkg::SIZE_W-1:0] instr_size;
		logic                        is_branch;
		logic                        is_conditional;
		logic [btbc_pkg::ADDR_W-1:0] next_address;
	} instr_item_t;

	typedef struct packed {
		logic [btbc_pkg::COST_W-1:0]  item_cycles;
		logic [btbc_pkg::TOTAL_W-1:0] total_cycles;
		logic                         btb_hit;
		logic                         mispredicted;
	} cost_item_t;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_style_t;

	// cost predictor with its own copy of the buffer and the registers
	class btb_cost_scoreboard;
		bit                           entry_valid[btbc_pkg::BTB_ENTRIES];
		bit [btbc_pkg::ADDR_W-1:0]    entry_tag[btbc_pkg::BTB_ENTRIES];
		bit                           entry_conditional[btbc_pkg::BTB_ENTRIES];
		bit [btbc_pkg::CTR_W-1:0]     entry_counter[btbc_pkg::BTB_ENTRIES];
		bit [btbc_pkg::TOTAL_W-1:0]   running_total;
		bit                           dynamic_mode;
		bit [btbc_pkg::COST_W-1:0]    mispredict_cost;
		bit [btbc_pkg::COST_W-1:0]    miss_cost;
		cost_item_t                   expected_costs[$];
		int errors;
		int accepted;
		int checked;
		int hits;
		int misses;
		int mispredicts;

		function new();
			foreach (entry_valid[i]) entry_valid[i] = 0;
			running_total   = '0;
			dynamic_mode    = btbc_pkg::RST_PREDICTOR_MODE;
			mispredict_cost = btbc_pkg::RST_MISPREDICT_PENALTY;
			miss_cost       = btbc_pkg::RST_BTB_MISS_PENALTY;
		endfunction

		function void set_register(logic [btbc_pkg::REG_IDX_W-1:0] idx,
			logic [btbc_pkg::PDATA_W-1:0] data);
			case (idx)
				btbc_pkg::REG_PREDICTOR_MODE:     dynamic_mode = data[0];
				btbc_pkg::REG_MISPREDICT_PENALTY: mispredict_cost = data[btbc_pkg::COST_W-1:0];
				btbc_pkg::REG_BTB_MISS_PENALTY:   miss_cost = data[btbc_pkg::COST_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_costs.size();
		endfunction

		// work out the cost item of one accepted instruction
		function void note_instr(instr_item_t it);
			cost_item_t exp_item;
			int slot;
			bit taken;
			bit pred_taken;
			exp_item.item_cycles  = btbc_pkg::BASE_COST;
			exp_item.btb_hit      = 1'b0;
			exp_item.mispredicted = 1'b0;
			accepted++;
			if (it.is_branch) begin
				slot = int'(it.instr_address % 64'(btbc_pkg::BTB_ENTRIES));
				if (entry_valid[slot] && entry_tag[slot] == it.instr_address) begin
					exp_item.btb_hit = 1'b1;
					hits++;
					// stored flag decides the class of the hit
					if (entry_conditional[slot]) begin
						taken = it.next_address != it.instr_address + 64'(it.instr_size);
						if (dynamic_mode) begin
							pred_taken = entry_counter[slot] >= btbc_pkg::CTR_TAKEN;
							if (taken) begin
								if (entry_counter[slot] != btbc_pkg::CTR_MAX)
									entry_counter[slot] = entry_counter[slot] + 2'd1;
							end else if (entry_counter[slot] != btbc_pkg::CTR_MIN) begin
								entry_counter[slot] = entry_counter[slot] - 2'd1;
							end
						end else begin
							pred_taken = 1'b0;
						end
						if (pred_taken != taken) begin
							exp_item.mispredicted = 1'b1;
							exp_item.item_cycles  = mispredict_cost;
							mispredicts++;
						end
					end
				end else begin
					// miss installs the entry with a cleared counter
					exp_item.item_cycles     = miss_cost;
					entry_valid[slot]        = 1'b1;
					entry_tag[slot]          = it.instr_address;
					entry_conditional[slot]  = it.is_conditional;
					entry_counter[slot]      = btbc_pkg::CTR_MIN;
					misses++;
				end
			end
			running_total = running_total + (btbc_pkg::TOTAL_W)'(exp_item.item_cycles);
			exp_item.total_cycles = running_total;
			expected_costs.push_back(exp_item);
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
				errors++;
			end
		endfunction

		// compare one result item with the oldest expectation
		function void check_result(cost_item_t act);
			cost_item_t exp_item;
			if (expected_costs.size() == 0) begin
				$display("%0t: unexpected result, expected none, got cycles %0d total %0d",
					$time, act.item_cycles, act.total_cycles);
				errors++;
			end else begin
				exp_item = expected_costs.pop_front();
				checked++;
				compare_field("item_cycles", 32'(exp_item.item_cycles), 32'(act.item_cycles));
				compare_field("total_cycles", exp_item.total_cycles, act.total_cycles);
				compare_field("btb_hit", 32'(exp_item.btb_hit), 32'(act.btb_hit));
				compare_field("mispredicted", 32'(exp_item.mispredicted), 32'(act.mispredicted));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [btbc_pkg::PADDR_W-1:0] paddr;
	logic [btbc_pkg::PDATA_W-1:0] pwdata;
	logic [btbc_pkg::PDATA_W-1:0] prdata;
	logic pready;

	btbc_instr_if  instr_ch();
	btbc_result_if result_ch();

	btb_two_bit_predictor_cost_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	btb_cost_scoreboard sb = new();

	// branch address pool for the random part
	logic [btbc_pkg::ADDR_W-1:0] pool_addr[POOL_SIZE];
	logic [btbc_pkg::SIZE_W-1:0] pool_size[POOL_SIZE];
	bit                          pool_cond[POOL_SIZE];
	int                          pool_bias[POOL_SIZE];

	int  burst_left;
	int  phases_run;
	bit  hold_request;

	// clock
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	// new pool, some entries share a slot with an earlier one
	function automatic void refill_pool();
		logic [btbc_pkg::ADDR_W-1:0] delta;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i >= 4 && $urandom_range(0, 3) == 0) begin
				delta = {$urandom, $urandom};
				delta[btbc_pkg::IDX_W-1:0] = '0;
				delta[btbc_pkg::IDX_W] = 1'b1;
				pool_addr[i] = pool_addr[i-4] ^ delta;
			end else begin
				pool_addr[i] = {$urandom, $urandom};
			end
			pool_size[i] = (btbc_pkg::SIZE_W)'($urandom);
			pool_cond[i] = $urandom_range(0, 3) != 0;
			pool_bias[i] = $urandom_range(0, 4) * 25;
		end
	endfunction

	// mostly pool branches with biased outcomes, plus plain and fresh noise
	function automatic instr_item_t make_item();
		instr_item_t it;
		int pick;
		int k;
		it.instr_address  = {$urandom, $urandom};
		it.instr_size     = (btbc_pkg::SIZE_W)'($urandom);
		it.is_branch      = 1'b0;
		it.is_conditional = 1'($urandom);
		it.next_address   = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			k = $urandom_range(0, POOL_SIZE - 1);
			it.instr_address  = pool_addr[k];
			it.instr_size     = pool_size[k];
			it.is_branch      = 1'b1;
			it.is_conditional = ($urandom_range(0, 9) == 0) ? ~pool_cond[k] : pool_cond[k];
			if ($urandom_range(0, 99) >= pool_bias[k])
				it.next_address = it.instr_address + 64'(it.instr_size);
			else if ($urandom_range(0, 3) == 0)
				it.next_address = it.instr_address;
		end else if (pick < 75) begin
			it.is_branch = 1'b1;
		end
		return it;
	endfunction

	function automatic instr_item_t branch_item(logic [btbc_pkg::ADDR_W-1:0] addr,
		logic [btbc_pkg::SIZE_W-1:0] size, logic cond, logic [btbc_pkg::ADDR_W-1:0] next);
		instr_item_t it;
		it.instr_address  = addr;
		it.instr_size     = size;
		it.is_branch      = 1'b1;
		it.is_conditional = cond;
		it.next_address   = next;
		return it;
	endfunction

	task automatic drive_payload(instr_item_t it);
		instr_ch.instr_address  <= it.instr_address;
		instr_ch.instr_size     <= it.instr_size;
		instr_ch.is_branch      <= it.is_branch;
		instr_ch.is_conditional <= it.is_conditional;
		instr_ch.next_address   <= it.next_address;
	endtask

	// offer one item until accepted, then maybe idle between bursts
	task automatic offer(instr_item_t it, bit no_gaps);
		int gap;
		instr_ch.valid <= 1'b1;
		drive_payload(it);
		do @(posedge clk); while (!instr_ch.ready);
		sb.note_instr(it);
		burst_left--;
		if (burst_left <= 0 && !no_gaps) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			instr_ch.valid <= 1'b0;
			drive_payload(make_item());
			repeat (gap) @(posedge clk);
		end
		if (burst_left <= 0)
			burst_left = $urandom_range(1, 40);
	endtask

	// setup and access cycle, then the bus is left idle
	task automatic apb_write(logic [btbc_pkg::REG_IDX_W-1:0] idx,
		logic [btbc_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= $urandom;
		@(posedge clk);
	endtask

	// wait until every cost item is back and the pipeline is empty
	task automatic drain();
		instr_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register setting followed by random items
	task automatic run_phase(logic mode, logic [btbc_pkg::COST_W-1:0] mp_cost,
		logic [btbc_pkg::COST_W-1:0] miss_cost, bit with_hold, bit with_spare);
		logic [btbc_pkg::PDATA_W-1:0] word;
		drain();
		word = $urandom;
		word[0] = mode;
		apb_write(btbc_pkg::REG_PREDICTOR_MODE, word);
		word = $urandom;
		word[btbc_pkg::COST_W-1:0] = mp_cost;
		apb_write(btbc_pkg::REG_MISPREDICT_PENALTY, word);
		word = $urandom;
		word[btbc_pkg::COST_W-1:0] = miss_cost;
		apb_write(btbc_pkg::REG_BTB_MISS_PENALTY, word);
		if (with_spare)
			apb_write(REG_SPARE, $urandom);
		phases_run++;
		refill_pool();
		if (with_hold)
			hold_request = 1'b1;
		for (int n = 0; n < PHASE_ITEMS; n++)
			offer(make_item(), with_hold && n < 100);
	endtask

	// receiver: checks results and stalls on its own pattern
	initial begin
		rx_style_t style;
		int style_left;
		int hold_left;
		int tick;
		result_ch.ready <= 1'b0;
		style = RX_ALWAYS;
		style_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				sb.check_result({result_ch.item_cycles, result_ch.total_cycles,
					result_ch.btb_hit, result_ch.mispredicted});
			tick++;
			if (style_left <= 0) begin
				style = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(50, 150);
			end
			style_left--;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (style)
					RX_ALWAYS:   result_ch.ready <= 1'b1;
					RX_RANDOM:   result_ch.ready <= 1'($urandom);
					RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: result_ch.ready <= (tick % 3) != 0;
				endcase
			end
		end
	end

	// reset, directed items, then random phases
	initial begin
		logic [btbc_pkg::ADDR_W-1:0] all_ones;
		logic [btbc_pkg::ADDR_W-1:0] near_top;
		int total_errors;
		all_ones = '1;
		near_top = all_ones - 64'd1;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		instr_ch.valid          = 1'b0;
		instr_ch.instr_address  = '0;
		instr_ch.instr_size     = '0;
		instr_ch.is_branch      = 1'b0;
		instr_ch.is_conditional = 1'b0;
		instr_ch.next_address   = '0;
		hold_request = 1'b0;
		phases_run   = 1;
		burst_left   = $urandom_range(1, 40);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// non-branches at the address extremes
		offer('{instr_address: '0, instr_size: '0, is_branch: 1'b0,
			is_conditional: 1'b1, next_address: all_ones}, 1'b0);
		offer('{instr_address: all_ones, instr_size: 4'hf, is_branch: 1'b0,
			is_conditional: 1'b0, next_address: '0}, 1'b0);
		// unconditional entry, hit with the input flag set
		offer(branch_item(all_ones, 4'hf, 1'b0, 64'h10), 1'b0);
		offer(branch_item(all_ones, 4'hf, 1'b1, 64'h10), 1'b0);
		// conditional entry: count up to saturation and back down
		offer(branch_item('0, 4'd4, 1'b1, 64'h100), 1'b0);
		repeat (4) offer(branch_item('0, 4'd4, 1'b1, 64'h100), 1'b0);
		repeat (4) offer(branch_item('0, 4'd4, 1'b1, 64'd4), 1'b0);
		// another tag in the same slot evicts the entry
		offer(branch_item(64'(btbc_pkg::BTB_ENTRIES), 4'd2, 1'b1, 64'h0), 1'b0);
		offer(branch_item('0, 4'd4, 1'b1, 64'd4), 1'b0);
		// fall-through address wraps past the top of the address space
		offer(branch_item(near_top, 4'hf, 1'b1, near_top + 64'hf), 1'b0);
		offer(branch_item(near_top, 4'hf, 1'b1, near_top + 64'hf), 1'b0);
		offer(branch_item(near_top, 4'hf, 1'b1, 64'h0), 1'b0);
		offer(branch_item(near_top, 4'hf, 1'b1, 64'h0), 1'b0);

		// random part at reset settings, then across register settings
		refill_pool();
		for (int n = 0; n < PHASE_ITEMS; n++)
			offer(make_item(), 1'b0);
		run_phase(1'b0, 8'd255, 8'd0, 1'b0, 1'b1);
		run_phase(1'b1, 8'd0, 8'd255, 1'b1, 1'b0);
		run_phase(1'b1, (btbc_pkg::COST_W)'($urandom), (btbc_pkg::COST_W)'($urandom),
			1'b0, 1'b0);
		run_phase(1'b0, (btbc_pkg::COST_W)'($urandom), (btbc_pkg::COST_W)'($urandom),
			1'b0, 1'b0);
		run_phase(1'b1, 8'd255, 8'd255, 1'b0, 1'b0);
		run_phase(1'b1, btbc_pkg::RST_MISPREDICT_PENALTY, btbc_pkg::RST_BTB_MISS_PENALTY,
			1'b0, 1'b1);
		drain();

		total_errors = sb.errors + sb.pending();
		$display("covered %0d instructions over %0d register settings: %0d hits, %0d misses",
			sb.accepted, phases_run, sb.hits, sb.misses);
		$display("%0d mispredictions, %0d results checked, %0d errors",
			sb.mispredicts, sb.checked, total_errors);
		if (total_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
